// ----- rtl/sfps_pkg.sv -----
// ----------------------------------------------------------------------------
// sfps_pkg
// Shared types and constants of the state feedback plant step block.
// ----------------------------------------------------------------------------
package sfps_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int MUL_STEPS     = 32;
    localparam int DIV_STEPS     = 64;
    localparam int CNT_W         = 6;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MLOAD,
        S_MSTEP,
        S_MSIGN,
        S_MACC,
        S_DLOAD,
        S_DSTEP,
        S_DFIN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_T1,
        OP_T2,
        OP_T3,
        OP_KU,
        OP_BV,
        OP_VDT,
        OP_ADT
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POS_GAIN   = 3'd0,
        CFG_VEL_GAIN   = 3'd1,
        CFG_REF_GAIN   = 3'd2,
        CFG_DAMPING    = 3'd3,
        CFG_DRIVE      = 3'd4,
        CFG_INERTIA    = 3'd5,
        CFG_TIME_STEP  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic              flag;
        logic [DATA_W-1:0] val;
    } t_sat;

endpackage

// ----- rtl/state_feedback_plant_step.sv -----
// ----------------------------------------------------------------------------
// state_feedback_plant_step
// State feedback controller closed around a forward-Euler second-order plant.
// ----------------------------------------------------------------------------
// A tick word computes u = -k1*x1 - k2*x2 + kr*r and advances position and
// velocity by one Euler step; a load word sets the state and returns it. All
// arithmetic runs on one bit-serial shift-add multiplier and one restoring
// divider. A new word is accepted only after the last result has gone into
// the output register, which may wait for the downstream side. The user must
// write configuration only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module state_feedback_plant_step #(
    parameter int FRAC_BITS = sfps_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [sfps_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sfps_pkg::DATA_W-1:0]     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // reference, init_position, init_velocity
    input  logic [3*sfps_pkg::DATA_W-1:0]   s_axis_tdata,
    // action
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // position, velocity, control
    output logic [3*sfps_pkg::DATA_W-1:0]   m_axis_tdata,
    // saturated
    output logic [0:0]                      m_axis_tuser
);

    import sfps_pkg::*;

    localparam logic [63:0] DT_FULL   = (64'd1 << FRAC_BITS) / 100;
    localparam logic [16:0] DT_RST    = (DT_FULL > 64'h1FFFF) ? 17'h1FFFF : DT_FULL[16:0];
    localparam logic [63:0] DAMP_FULL = 64'd10 << FRAC_BITS;
    localparam logic [63:0] DRV_FULL  = 64'd100 << FRAC_BITS;

    function automatic t_sat f_sat32(input logic signed [63:0] v);
        t_sat res;
        res.flag = (v[63:31] != {33{v[63]}});
        if (res.flag) begin
            res.val = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res.val = v[31:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;
    t_op    r_op;

    logic [31:0] r_k1, r_k2, r_kr;
    logic [30:0] r_damp, r_drive, r_inertia;
    logic [16:0] r_dt;

    logic [31:0] r_x1, r_x2, r_ref, r_u, r_acc;
    logic        r_sat;
    logic signed [63:0] r_sum;

    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_mcand;
    logic [64:0]      r_prod;
    logic             r_pneg;

    logic [30:0] r_rem, r_div;
    logic [63:0] r_quo;
    logic        r_dneg;

    logic                    r_m_valid;
    logic [3*DATA_W-1:0]     r_m_data;
    logic                    r_m_user;

    logic s_accept, out_load, mul_last, div_last;

    logic signed [32:0] op_a, op_b;
    logic [32:0]        a_neg, b_neg;
    logic [31:0]        a_mag, b_mag;
    logic [32:0]        mul_hi;
    logic signed [63:0] prod_s, prod_sh, add_base, add_res;
    logic [63:0]        prod_neg, sum_abs;
    t_sat               add_sat;
    logic [32:0]        trial;
    logic [31:0]        q_neg;
    logic               q_ovf;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    always_comb begin
        unique case (r_op)
            OP_T1:   begin op_a = {r_k1[31], r_k1};   op_b = {r_x1[31], r_x1};  end
            OP_T2:   begin op_a = {r_k2[31], r_k2};   op_b = {r_x2[31], r_x2};  end
            OP_T3:   begin op_a = {r_kr[31], r_kr};   op_b = {r_ref[31], r_ref}; end
            OP_KU:   begin op_a = {2'b00, r_drive};   op_b = {r_u[31], r_u};    end
            OP_BV:   begin op_a = {2'b00, r_damp};    op_b = {r_x2[31], r_x2};  end
            OP_VDT:  begin op_a = {r_x2[31], r_x2};   op_b = {16'd0, r_dt};     end
            OP_ADT:  begin op_a = {r_acc[31], r_acc}; op_b = {16'd0, r_dt};     end
            default: begin op_a = '0;                 op_b = '0;                end
        endcase
    end

    assign a_neg  = -op_a;
    assign b_neg  = -op_b;
    assign a_mag  = op_a[32] ? a_neg[31:0] : op_a[31:0];
    assign b_mag  = op_b[32] ? b_neg[31:0] : op_b[31:0];
    assign mul_hi = r_prod[64:32] + (r_prod[0] ? {1'b0, r_mcand} : 33'd0);

    assign prod_neg = -r_prod[63:0];
    assign prod_s   = $signed(r_prod[63:0]);
    assign prod_sh  = prod_s >>> FRAC_BITS;

    always_comb begin
        unique case (r_op)
            OP_T3:   add_base = r_sum;
            OP_VDT:  add_base = {{32{r_x1[31]}}, r_x1};
            default: add_base = {{32{r_x2[31]}}, r_x2};
        endcase
    end

    assign add_res = add_base + prod_sh;
    assign add_sat = f_sat32(add_res);

    assign sum_abs = r_sum[63] ? 64'(-r_sum) : r_sum;
    assign trial   = {1'b0, r_rem, r_quo[63]} - {2'b00, r_div};
    assign q_neg   = -r_quo[31:0];
    assign q_ovf   = r_dneg ? ((r_quo[63:32] != '0) || (r_quo[31] && (r_quo[30:0] != '0)))
                            : (r_quo[63:31] != '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_accept) n_state = s_axis_tuser[0] ? S_DONE : S_MLOAD;
            S_MLOAD: n_state = S_MSTEP;
            S_MSTEP: if (mul_last) n_state = S_MSIGN;
            S_MSIGN: n_state = S_MACC;
            S_MACC: begin
                unique case (r_op)
                    OP_BV:   n_state = S_DLOAD;
                    OP_ADT:  n_state = S_DONE;
                    default: n_state = S_MLOAD;
                endcase
            end
            S_DLOAD: n_state = S_DSTEP;
            S_DSTEP: if (div_last) n_state = S_DFIN;
            S_DFIN:  n_state = S_MLOAD;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        out_load      = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);
        mul_last      = (r_state == S_MSTEP) && (r_cnt == MUL_LAST);
        div_last      = (r_state == S_DSTEP) && (r_cnt == DIV_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1      <= '0;
            r_k2      <= '0;
            r_kr      <= '0;
            r_damp    <= DAMP_FULL[30:0];
            r_drive   <= DRV_FULL[30:0];
            r_inertia <= DRV_FULL[30:0];
            r_dt      <= DT_RST;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_POS_GAIN:  r_k1      <= i_cfg_wdata;
                CFG_VEL_GAIN:  r_k2      <= i_cfg_wdata;
                CFG_REF_GAIN:  r_kr      <= i_cfg_wdata;
                CFG_DAMPING:   r_damp    <= i_cfg_wdata[30:0];
                CFG_DRIVE:     r_drive   <= i_cfg_wdata[30:0];
                CFG_INERTIA:   r_inertia <= i_cfg_wdata[30:0];
                CFG_TIME_STEP: r_dt      <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1  <= '0;
            r_x2  <= '0;
            r_op  <= OP_T1;
            r_sat <= 1'b0;
            r_u   <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_op  <= OP_T1;
                        r_sat <= 1'b0;
                        r_u   <= '0;
                        r_ref <= s_axis_tdata[31:0];
                        if (s_axis_tuser[0]) begin
                            r_x1 <= s_axis_tdata[63:32];
                            r_x2 <= s_axis_tdata[95:64];
                        end
                    end
                end
                S_MLOAD: begin
                    r_cnt   <= '0;
                    r_mcand <= a_mag;
                    r_prod  <= {33'd0, b_mag};
                    r_pneg  <= op_a[32] ^ op_b[32];
                end
                S_MSTEP: begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_prod <= {1'b0, mul_hi, r_prod[31:1]};
                end
                S_MSIGN: begin
                    if (r_pneg) begin
                        r_prod <= {1'b0, prod_neg};
                    end
                end
                S_MACC: begin
                    unique case (r_op)
                        OP_T1: begin
                            r_sum <= -prod_sh;
                            r_op  <= OP_T2;
                        end
                        OP_T2: begin
                            r_sum <= r_sum - prod_sh;
                            r_op  <= OP_T3;
                        end
                        OP_T3: begin
                            r_u   <= add_sat.val;
                            r_sat <= r_sat | add_sat.flag;
                            r_op  <= OP_KU;
                        end
                        OP_KU: begin
                            r_sum <= -prod_s;
                            r_op  <= OP_BV;
                        end
                        OP_BV: begin
                            r_sum <= r_sum - prod_s;
                            r_op  <= OP_VDT;
                        end
                        OP_VDT: begin
                            r_x1  <= add_sat.val;
                            r_sat <= r_sat | add_sat.flag;
                            r_op  <= OP_ADT;
                        end
                        OP_ADT: begin
                            r_x2  <= add_sat.val;
                            r_sat <= r_sat | add_sat.flag;
                            r_op  <= OP_T1;
                        end
                        default: r_op <= OP_T1;
                    endcase
                end
                S_DLOAD: begin
                    r_cnt  <= '0;
                    r_dneg <= r_sum[63];
                    r_quo  <= sum_abs;
                    r_rem  <= '0;
                    r_div  <= (r_inertia == '0) ? 31'd1 : r_inertia;
                end
                S_DSTEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (!trial[32]) begin
                        r_rem <= trial[30:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[29:0], r_quo[63]};
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                end
                S_DFIN: begin
                    r_sat <= r_sat | q_ovf;
                    if (q_ovf) begin
                        r_acc <= r_dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end else begin
                        r_acc <= r_dneg ? q_neg : r_quo[31:0];
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {r_u, r_x2, r_x1};
            r_m_user <= r_sat;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != S_IDLE))
        else $error("state stayed idle after an accepted word");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

    a_mul_high_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MSTEP) |-> (!r_prod[64] && (r_cnt <= MUL_LAST)))
        else $error("multiplier accumulator or count out of range");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTEP) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_div_then_integrate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DLOAD) |-> (r_op == OP_VDT))
        else $error("division entered out of sequence");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the state feedback plant step block.
// ----------------------------------------------------------------------------
// Tick and load words go in on the slave stream. Every result word is
// compared with a bench-side model of the controller and the Euler plant,
// which keeps its own copy of the registers and the state. A short directed
// table with the reset settings comes first. It is followed by phases of
// random words, each under a new register setting. The settings include the
// largest and the smallest gains, a zero inertia and a zero time step. Both
// stream sides idle in short random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_top;
    import sfps_pkg::*;

    localparam int          FRAC     = FRAC_BITS_DEF;
    localparam int          N_PHASE  = 12;
    localparam int          N_RAND   = 75;
    localparam bit          ACT_TICK = 1'b0;
    localparam bit          ACT_LOAD = 1'b1;
    localparam longint      S32_MAX  = 64'sd2147483647;
    localparam longint      S32_MIN  = -64'sd2147483648;
    localparam logic [31:0] MAX32    = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32    = 32'h8000_0000;
    localparam logic [31:0] ONES32   = 32'hFFFF_FFFF;

    typedef struct {
        logic        action;
        logic [31:0] reference;
        logic [31:0] init_pos;
        logic [31:0] init_vel;
    } t_plant_word;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] ctl;
        logic        sat;
    } t_plant_result;

    typedef struct {
        t_plant_word   w;
        bit            typed;
        t_plant_result res;
    } t_directed_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wen;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [DATA_W-1:0]       i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [3*DATA_W-1:0]     s_axis_tdata;   // reference, init_position, init_velocity
    logic [0:0]              s_axis_tuser;   // action
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [3*DATA_W-1:0]     m_axis_tdata;   // position, velocity, control
    logic [0:0]              m_axis_tuser;   // saturated

    logic [31:0] k_pos, k_vel, k_ref;
    logic [30:0] damp, drive, inert;
    logic [16:0] dstep;
    longint      pos_now, vel_now;

    t_plant_result expected_results[$];
    int            n_errors = 0;
    int            n_ticks  = 0;
    int            n_loads  = 0;
    int            n_sat    = 0;
    bit            idle_on   = 1'b1;
    bit            calm_tail = 1'b0;

    state_feedback_plant_step DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic bit beyond32(longint v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

    // A load, or one controller evaluation and Euler step, on the bench state copy.
    function automatic t_plant_result plant_step(t_plant_word w);
        t_plant_result o;
        longint        x1, x2, r, j, dt, sum, u, num, acc, np, nv;
        bit            sat;
        if (w.action == ACT_LOAD) begin
            pos_now = longint'($signed(w.init_pos));
            vel_now = longint'($signed(w.init_vel));
            o.pos = w.init_pos;
            o.vel = w.init_vel;
            o.ctl = '0;
            o.sat = 1'b0;
            return o;
        end
        x1  = pos_now;
        x2  = vel_now;
        r   = longint'($signed(w.reference));
        sat = 1'b0;
        sum = -((longint'($signed(k_pos)) * x1) >>> FRAC)
              - ((longint'($signed(k_vel)) * x2) >>> FRAC)
              + ((longint'($signed(k_ref)) * r) >>> FRAC);
        sat = sat | beyond32(sum);
        u   = clamp32(sum);
        j   = longint'(inert);
        if (j == 0) j = 1;
        dt  = longint'(dstep);
        num = -(longint'(drive) * u) - longint'(damp) * x2;
        acc = num / j;
        sat = sat | beyond32(acc);
        acc = clamp32(acc);
        np  = x1 + ((x2 * dt) >>> FRAC);
        nv  = x2 + ((acc * dt) >>> FRAC);
        sat = sat | beyond32(np) | beyond32(nv);
        pos_now = clamp32(np);
        vel_now = clamp32(nv);
        o.pos = pos_now[31:0];
        o.vel = vel_now[31:0];
        o.ctl = u[31:0];
        o.sat = sat;
        return o;
    endfunction

    function automatic t_directed_row make_row(logic act, logic [31:0] r, logic [31:0] ip,
                                               logic [31:0] iv, bit typed, logic [31:0] ep,
                                               logic [31:0] ev);
        t_directed_row row;
        row.w.action    = act;
        row.w.reference = r;
        row.w.init_pos  = ip;
        row.w.init_vel  = iv;
        row.typed       = typed;
        row.res.pos     = ep;
        row.res.vel     = ev;
        row.res.ctl     = '0;
        row.res.sat     = 1'b0;
        return row;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_word(t_plant_word w, bit typed, t_plant_result typed_res);
        t_plant_result predicted;
        if (idle_on && !calm_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {w.init_vel, w.init_pos, w.reference};
        s_axis_tuser  = w.action;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = plant_step(w);
        if (typed) predicted = typed_res;
        expected_results = {expected_results, predicted};
        if (w.action == ACT_LOAD) n_loads++;
        else n_ticks++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_plant_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result word, expected none, got %h / %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_results.pop_front();
                check_field("position", want.pos, m_axis_tdata[31:0]);
                check_field("velocity", want.vel, m_axis_tdata[63:32]);
                check_field("control", want.ctl, m_axis_tdata[95:64]);
                check_field("saturated", {31'b0, want.sat}, {31'b0, m_axis_tuser[0]});
                if (m_axis_tuser[0]) n_sat++;
            end
        end
    end

    initial begin
        int hold;
        m_axis_tready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready = 1'b0;
                hold--;
            end else if (idle_on && !calm_tail && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                hold = $urandom_range(0, 2);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin
        #15_000_000;
        $display("Timeout: the streams stopped making progress");
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_directed_row rows[$];
        logic [31:0]   cfg_val [7];
        t_plant_word   w;
        t_plant_result none;

        i_rst_n       = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        none.pos = '0;
        none.vel = '0;
        none.ctl = '0;
        none.sat = 1'b0;

        k_pos   = '0;
        k_vel   = '0;
        k_ref   = '0;
        damp    = 31'(10 << FRAC);
        drive   = 31'(100 << FRAC);
        inert   = 31'(100 << FRAC);
        dstep   = 17'((1 << FRAC) / 100);
        pos_now = 0;
        vel_now = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Gains are zero after reset, so ticks from a zero state stay at zero.
        rows = {rows, make_row(ACT_TICK, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_TICK, MAX32, ONES32, ONES32, 1, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_TICK, MIN32, MAX32, MIN32, 1, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_LOAD, ONES32, MAX32, MIN32, 1, MAX32, MIN32)};
        rows = {rows, make_row(ACT_TICK, 32'h0001_0000, 32'h0, 32'h0, 0, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_TICK, 32'h0, ONES32, 32'h0, 0, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_LOAD, 32'h5555_5555, MIN32, MAX32, 1, MIN32, MAX32)};
        rows = {rows, make_row(ACT_TICK, 32'hAAAA_AAAA, 32'h0, ONES32, 0, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_LOAD, 32'h0, MAX32, MAX32, 1, MAX32, MAX32)};
        rows = {rows, make_row(ACT_TICK, 32'h0, 32'h0, 32'h0, 0, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_LOAD, MAX32, MIN32, MIN32, 1, MIN32, MIN32)};
        rows = {rows, make_row(ACT_TICK, MIN32, 32'h0, 32'h0, 0, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_LOAD, MIN32, ONES32, ONES32, 1, ONES32, ONES32)};
        rows = {rows, make_row(ACT_TICK, ONES32, 32'h0, 32'h0, 0, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_LOAD, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_TICK, MAX32, 32'h1234_5678, 32'h0, 1, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_LOAD, 32'h0, 32'h0064_0000, 32'h000A_0000, 1,
                               32'h0064_0000, 32'h000A_0000)};
        rows = {rows, make_row(ACT_TICK, 32'h0, 32'h0, 32'h0, 0, 32'h0, 32'h0)};
        rows = {rows, make_row(ACT_TICK, 32'hFFFF_0000, 32'h0, 32'h0, 0, 32'h0, 32'h0)};

        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

        for (int p = 1; p <= N_PHASE; p++) begin
            wait_drain();
            calm_tail = (p == N_PHASE);

            // A loop that stays mostly in range, then the special settings.
            cfg_val[CFG_POS_GAIN]  = $urandom_range(0, 40 << FRAC);
            cfg_val[CFG_VEL_GAIN]  = $urandom_range(0, 20 << FRAC);
            cfg_val[CFG_REF_GAIN]  = $urandom_range(0, 60 << FRAC);
            for (int i = int'(CFG_POS_GAIN); i <= int'(CFG_REF_GAIN); i++) begin
                if ($urandom_range(0, 3) == 0) cfg_val[i] = -cfg_val[i];
            end
            cfg_val[CFG_DAMPING]   = $urandom_range(0, 50 << FRAC);
            cfg_val[CFG_DRIVE]     = $urandom_range(1 << FRAC, 200 << FRAC);
            cfg_val[CFG_INERTIA]   = $urandom_range(1 << FRAC, 200 << FRAC);
            cfg_val[CFG_TIME_STEP] = $urandom_range(1, (1 << FRAC) / 10);
            case (p)
                1: begin
                    cfg_val[CFG_POS_GAIN]  = MAX32;
                    cfg_val[CFG_VEL_GAIN]  = MAX32;
                    cfg_val[CFG_REF_GAIN]  = MAX32;
                    cfg_val[CFG_DAMPING]   = MAX32;
                    cfg_val[CFG_DRIVE]     = MAX32;
                    cfg_val[CFG_INERTIA]   = MAX32;
                    cfg_val[CFG_TIME_STEP] = 32'h0001_0000;
                end
                2: begin
                    cfg_val[CFG_POS_GAIN]  = MIN32;
                    cfg_val[CFG_VEL_GAIN]  = MIN32;
                    cfg_val[CFG_REF_GAIN]  = MIN32;
                    cfg_val[CFG_DAMPING]   = 32'h0;
                    cfg_val[CFG_DRIVE]     = 32'h0;
                    cfg_val[CFG_INERTIA]   = 32'h1;
                    cfg_val[CFG_TIME_STEP] = 32'h1;
                end
                3: begin
                    cfg_val[CFG_INERTIA] = 32'h0;
                end
                4: begin
                    cfg_val[CFG_TIME_STEP] = 32'h0;
                end
                N_PHASE - 1: begin
                    cfg_val[CFG_POS_GAIN]  = $urandom();
                    cfg_val[CFG_VEL_GAIN]  = $urandom();
                    cfg_val[CFG_REF_GAIN]  = $urandom();
                    cfg_val[CFG_DAMPING]   = $urandom() >> 1;
                    cfg_val[CFG_DRIVE]     = $urandom() >> 1;
                    cfg_val[CFG_INERTIA]   = $urandom_range(1, MAX32);
                    cfg_val[CFG_TIME_STEP] = $urandom_range(1, 1 << FRAC);
                end
                default: begin
                end
            endcase

            for (int i = int'(CFG_POS_GAIN); i <= int'(CFG_TIME_STEP); i++) begin
                i_cfg_wen   = 1'b1;
                i_cfg_addr  = t_cfg_idx'(i);
                i_cfg_wdata = cfg_val[i];
                @(posedge i_clk);
                case (t_cfg_idx'(i))
                    CFG_POS_GAIN:  k_pos = cfg_val[i];
                    CFG_VEL_GAIN:  k_vel = cfg_val[i];
                    CFG_REF_GAIN:  k_ref = cfg_val[i];
                    CFG_DAMPING:   damp  = cfg_val[i][30:0];
                    CFG_DRIVE:     drive = cfg_val[i][30:0];
                    CFG_INERTIA:   inert = cfg_val[i][30:0];
                    CFG_TIME_STEP: dstep = cfg_val[i][16:0];
                    default: begin
                    end
                endcase
                @(negedge i_clk);
            end
            i_cfg_wen = 1'b0;

            for (int n = 0; n < N_RAND; n++) begin
                if (n % 16 == 0) idle_on = ($urandom_range(0, 3) != 0);
                if (p == 6 && n == 30) wait_drain();
                w.action = ($urandom_range(0, 9) == 0) ? ACT_LOAD : ACT_TICK;
                if ($urandom_range(0, 7) == 0) begin
                    w.reference = $urandom();
                end else begin
                    w.reference = 32'($urandom_range(0, 200 << FRAC)) - 32'(100 << FRAC);
                end
                if (w.action == ACT_LOAD && $urandom_range(0, 3) != 0) begin
                    w.init_pos = 32'($urandom_range(0, 64 << FRAC)) - 32'(32 << FRAC);
                    w.init_vel = 32'($urandom_range(0, 64 << FRAC)) - 32'(32 << FRAC);
                end else begin
                    w.init_pos = $urandom();
                    w.init_vel = $urandom();
                end
                send_word(w, 1'b0, none);
            end
        end

        wait_drain();
        repeat (320) @(posedge i_clk);
        $display("Ran %0d tick and %0d load words over %0d register settings,",
                 n_ticks, n_loads, N_PHASE + 1);
        $display("zero inertia and zero step included; %0d results reported a clamp.", n_sat);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
